### src/fogb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fogb_pkg
// Shared types and constants for the vertex distance fog blend pipeline.
// ----------------------------------------------------------------------------
package fogb_pkg;

  localparam int unsigned FracBits  = 8;
  localparam int unsigned FullScale = 256;
  localparam int unsigned QuoBits   = FracBits + 1;
  localparam logic [7:0]  ChanKeep  = 8'hF8;

  // reset values of the derived distance terms
  localparam logic [31:0] Near2Reset = 32'd1562500;
  localparam logic [31:0] Far2Reset  = 32'd351562500;
  localparam logic [23:0] DivReset   = 24'd1373291;

  typedef enum logic [1:0] {
    RegionNear  = 2'd0,
    RegionBlend = 2'd1,
    RegionFar   = 2'd2
  } fogb_region_e;

  typedef enum logic [2:0] {
    CfgFogColor  = 3'd0,
    CfgNearDist  = 3'd1,
    CfgFarDist   = 3'd2,
    CfgAlphaGain = 3'd3,
    CfgCamX      = 3'd4,
    CfgCamY      = 3'd5,
    CfgCamZ      = 3'd6
  } fogb_cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eob;
  } fogb_side_t;

  typedef struct packed {
    logic [31:0]        rem;
    logic [QuoBits-1:0] quo;
    fogb_region_e       region;
    fogb_side_t         side;
  } fogb_div_t;

endpackage
`default_nettype wire

### src/fogb_dist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fogb_dist
// Four-stage squared distance front end: capture, per-axis squares, sum minus
// near squared, then region classification.
// ----------------------------------------------------------------------------
module fogb_dist import fogb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] vert_x_i,
  input  wire logic signed [15:0] vert_y_i,
  input  wire logic signed [15:0] vert_z_i,
  input  wire fogb_side_t         side_i,
  input  wire logic signed [15:0] cam_x_i,
  input  wire logic signed [15:0] cam_y_i,
  input  wire logic signed [15:0] cam_z_i,
  input  wire logic [31:0]        near2_i,
  input  wire logic [31:0]        far2_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output fogb_div_t               out_data_o
);

  localparam int NumStages = 4;

  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   ready;

  logic signed [15:0] vx_q, vy_q, vz_q;
  fogb_side_t         side_a_q, side_b_q, side_c_q;
  logic signed [15:0] dx, dy, dz;
  logic signed [31:0] sqx_d, sqy_d, sqz_d;
  logic signed [31:0] sqx_q, sqy_q, sqz_q;
  logic [31:0]        sum_d, sum_q;
  fogb_div_t          out_d, out_q;

  assign ready[NumStages] = out_ready_i;
  for (genvar k = 0; k < NumStages; k++) begin : g_ready
    assign ready[k] = !valid_q[k] || ready[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (ready[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // stage A: capture, keep top five bits of each channel
  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      vx_q           <= vert_x_i;
      vy_q           <= vert_y_i;
      vz_q           <= vert_z_i;
      side_a_q.red   <= side_i.red & ChanKeep;
      side_a_q.green <= side_i.green & ChanKeep;
      side_a_q.blue  <= side_i.blue & ChanKeep;
      side_a_q.eob   <= side_i.eob;
    end
  end

  // stage B: wrapped differences squared
  always_comb begin
    dx    = cam_x_i - vx_q;
    dy    = cam_y_i - vy_q;
    dz    = cam_z_i - vz_q;
    sqx_d = dx * dx;
    sqy_d = dy * dy;
    sqz_d = dz * dz;
  end

  always_ff @(posedge clk_i) begin
    if (ready[1]) begin
      sqx_q    <= sqx_d;
      sqy_q    <= sqy_d;
      sqz_q    <= sqz_d;
      side_b_q <= side_a_q;
    end
  end

  // stage C: sum minus near squared, 32-bit wrap
  assign sum_d = 32'(sqx_q) + 32'(sqy_q) + 32'(sqz_q) - near2_i;

  always_ff @(posedge clk_i) begin
    if (ready[2]) begin
      sum_q    <= sum_d;
      side_c_q <= side_b_q;
    end
  end

  // stage D: classify
  always_comb begin
    out_d.rem  = sum_q;
    out_d.quo  = '0;
    out_d.side = side_c_q;
    if (sum_q[31]) begin
      out_d.region = RegionNear;
    end else if (sum_q > far2_i) begin
      out_d.region = RegionFar;
    end else begin
      out_d.region = RegionBlend;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[3]) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### src/fogb_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fogb_div
// Pipelined restoring divider for the blend factor, three quotient bits per
// stage. The dividend is below 512 times the divisor in the blend region.
// ----------------------------------------------------------------------------
module fogb_div import fogb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire fogb_div_t   in_data_i,
  input  wire logic [23:0] div_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output fogb_div_t        out_data_o
);

  localparam int BitsPerStage = 3;
  localparam int NumStages    = QuoBits / BitsPerStage;

  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   ready;
  fogb_div_t            data_q [NumStages];
  fogb_div_t            data_d [NumStages];

  assign ready[NumStages] = out_ready_i;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    fogb_div_t src;

    assign ready[s] = !valid_q[s] || ready[s+1];

    if (s == 0) begin : g_first
      assign src = in_data_i;
    end else begin : g_next
      assign src = data_q[s-1];
    end

    always_comb begin
      logic [3:0]  idx;
      logic [32:0] shdiv;
      data_d[s] = src;
      for (int j = 0; j < BitsPerStage; j++) begin
        idx   = 4'(QuoBits - 1 - s * BitsPerStage - j);
        shdiv = 33'(div_i) << idx;
        if ({1'b0, data_d[s].rem} >= shdiv) begin
          data_d[s].rem      = data_d[s].rem - shdiv[31:0];
          data_d[s].quo[idx] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[s]) begin
        data_q[s] <= data_d[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (ready[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign out_data_o  = data_q[NumStages-1];

endmodule
`default_nettype wire

### src/fogb_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fogb_blend
// Two-stage back end: clamp factor and form channel and alpha products, then
// scale alpha by the gain and select the per-region result.
// ----------------------------------------------------------------------------
module fogb_blend import fogb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire fogb_div_t   in_data_i,
  input  wire logic [23:0] fog_color_i,
  input  wire logic [8:0]  alpha_gain_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_red_o,
  output logic [7:0]       out_green_o,
  output logic [7:0]       out_blue_o,
  output logic [7:0]       out_alpha_o,
  output logic [1:0]       fog_region_o,
  output logic             batch_done_o
);

  logic [1:0] valid_q;
  logic [2:0] ready;

  logic [7:0]  fog_r, fog_g, fog_b;
  logic [8:0]  f, inv;
  logic [16:0] mix_r, mix_g, mix_b;
  logic [17:0] isq;

  fogb_region_e region_q;
  fogb_side_t   side_q;
  logic [7:0]   mix_r_q, mix_g_q, mix_b_q;
  logic [8:0]   invsq_q;

  logic [17:0] ag;
  logic [7:0]  alpha_blend, gain_sat;
  logic [7:0]  red_d, green_d, blue_d, alpha_d;
  logic [7:0]  red_q, green_q, blue_q, alpha_q;
  logic [1:0]  region_oq;
  logic        eob_q;

  assign ready[2] = out_ready_i;
  assign ready[1] = !valid_q[1] || ready[2];
  assign ready[0] = !valid_q[0] || ready[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) valid_q[0] <= in_valid_i;
      if (ready[1]) valid_q[1] <= valid_q[0];
    end
  end

  assign fog_r = fog_color_i[23:16];
  assign fog_g = fog_color_i[15:8];
  assign fog_b = fog_color_i[7:0];

  // stage P: factor clamp and products
  always_comb begin
    f     = (in_data_i.quo > 9'(FullScale)) ? 9'(FullScale) : in_data_i.quo;
    inv   = 9'(FullScale) - f;
    mix_r = 17'(in_data_i.side.red) * 17'(inv) + 17'(fog_r) * 17'(f);
    mix_g = 17'(in_data_i.side.green) * 17'(inv) + 17'(fog_g) * 17'(f);
    mix_b = 17'(in_data_i.side.blue) * 17'(inv) + 17'(fog_b) * 17'(f);
    isq   = 18'(inv) * 18'(inv);
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      region_q <= in_data_i.region;
      side_q   <= in_data_i.side;
      mix_r_q  <= mix_r[15:8];
      mix_g_q  <= mix_g[15:8];
      mix_b_q  <= mix_b[15:8];
      invsq_q  <= isq[16:8];
    end
  end

  // stage O: alpha scaling and region select
  always_comb begin
    ag          = 18'(invsq_q) * 18'(alpha_gain_i);
    alpha_blend = (ag[17:16] != 2'b00) ? 8'hFF : ag[15:8];
    gain_sat    = alpha_gain_i[8] ? 8'hFF : alpha_gain_i[7:0];
    case (region_q)
      RegionNear: begin
        red_d   = side_q.red;
        green_d = side_q.green;
        blue_d  = side_q.blue;
        alpha_d = gain_sat;
      end
      RegionFar: begin
        red_d   = fog_r;
        green_d = fog_g;
        blue_d  = fog_b;
        alpha_d = 8'd0;
      end
      default: begin
        red_d   = mix_r_q;
        green_d = mix_g_q;
        blue_d  = mix_b_q;
        alpha_d = alpha_blend;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ready[1]) begin
      red_q     <= red_d;
      green_q   <= green_d;
      blue_q    <= blue_d;
      alpha_q   <= alpha_d;
      region_oq <= region_q;
      eob_q     <= side_q.eob;
    end
  end

  assign in_ready_o   = ready[0];
  assign out_valid_o  = valid_q[1];
  assign out_red_o    = red_q;
  assign out_green_o  = green_q;
  assign out_blue_o   = blue_q;
  assign out_alpha_o  = alpha_q;
  assign fog_region_o = region_oq;
  assign batch_done_o = eob_q;

endmodule
`default_nettype wire

### src/vertex_distance_fog_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_distance_fog_blend
// Linear distance fog for one vertex word: squared camera distance, region
// classification, pipelined factor divide and color/alpha blend.
// ----------------------------------------------------------------------------
// Stages: 4 distance, 3 divider, 2 blend, the last one the output register.
// Throughput: one word per cycle while the output is not stalled;
//   the divider retires 3 quotient bits a stage.
// Reset: async active low; clears valid bits and loads register defaults,
//   including the derived near/far squared terms. No clearing pass.
module vertex_distance_fog_blend import fogb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] vert_x_i,
  input  wire logic signed [15:0] vert_y_i,
  input  wire logic signed [15:0] vert_z_i,
  input  wire logic [7:0]         orig_red_i,
  input  wire logic [7:0]         orig_green_i,
  input  wire logic [7:0]         orig_blue_i,
  input  wire logic               end_of_batch_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              out_red_o,
  output logic [7:0]              out_green_o,
  output logic [7:0]              out_blue_o,
  output logic [7:0]              out_alpha_o,
  output logic [1:0]              fog_region_o,
  output logic                    batch_done_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i
);

  logic [23:0]        fog_color_q;
  logic [15:0]        near_dist_q, far_dist_q;
  logic [8:0]         alpha_gain_q;
  logic signed [15:0] cam_x_q, cam_y_q, cam_z_q;
  logic [31:0]        near2_q, far2_q;
  logic [23:0]        div_q;

  fogb_side_t side_in;
  logic       in_ready;
  logic       dist_valid, dist_ready, div_valid, div_ready;
  fogb_div_t  dist_data, div_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fog_color_q  <= 24'd1054789;
      near_dist_q  <= 16'd1250;
      far_dist_q   <= 16'd18750;
      alpha_gain_q <= 9'd153;
      cam_x_q      <= '0;
      cam_y_q      <= '0;
      cam_z_q      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgFogColor:  fog_color_q  <= cfg_data_i;
        CfgNearDist:  near_dist_q  <= cfg_data_i[15:0];
        CfgFarDist:   far_dist_q   <= cfg_data_i[15:0];
        CfgAlphaGain: alpha_gain_q <= cfg_data_i[8:0];
        CfgCamX:      cam_x_q      <= cfg_data_i[15:0];
        CfgCamY:      cam_y_q      <= cfg_data_i[15:0];
        CfgCamZ:      cam_z_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // derived distance terms: near2_q and far2_q registered from the distance registers, div_q from far2_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near2_q <= Near2Reset;
      far2_q  <= Far2Reset;
      div_q   <= DivReset;
    end else begin
      near2_q <= 32'(near_dist_q) * 32'(near_dist_q);
      far2_q  <= 32'(far_dist_q) * 32'(far_dist_q);
      div_q   <= (far2_q[31:8] == 24'd0) ? 24'd1 : far2_q[31:8];
    end
  end

  assign side_in.red   = orig_red_i;
  assign side_in.green = orig_green_i;
  assign side_in.blue  = orig_blue_i;
  assign side_in.eob   = end_of_batch_i;

  fogb_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .vert_x_i    (vert_x_i),
    .vert_y_i    (vert_y_i),
    .vert_z_i    (vert_z_i),
    .side_i      (side_in),
    .cam_x_i     (cam_x_q),
    .cam_y_i     (cam_y_q),
    .cam_z_i     (cam_z_q),
    .near2_i     (near2_q),
    .far2_i      (far2_q),
    .out_valid_o (dist_valid),
    .out_ready_i (dist_ready),
    .out_data_o  (dist_data)
  );

  fogb_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dist_valid),
    .in_ready_o  (dist_ready),
    .in_data_i   (dist_data),
    .div_i       (div_q),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_data_o  (div_data)
  );

  fogb_blend u_blend (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (div_valid),
    .in_ready_o   (div_ready),
    .in_data_i    (div_data),
    .fog_color_i  (fog_color_q),
    .alpha_gain_i (alpha_gain_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (!out_stall_i),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .out_alpha_o  (out_alpha_o),
    .fog_region_o (fog_region_o),
    .batch_done_o (batch_done_o)
  );

  assign in_stall_o = !in_ready;

  // input backpressure only when the output side is blocked
  a_stall_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled while output is free");

  a_far_alpha_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fog_region_o == RegionFar) |-> out_alpha_o == 8'd0)
    else $error("far region word with nonzero alpha");

  a_near_color_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fog_region_o == RegionNear) |->
      (out_red_o[2:0] == 3'd0 && out_green_o[2:0] == 3'd0 && out_blue_o[2:0] == 3'd0))
    else $error("near region color not truncated");

endmodule
`default_nettype wire

### tb/sv/vertex_distance_fog_blend_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_distance_fog_blend_tb
// Drives vertex words into the fog blend pipeline under random gaps and
// output stalls, recomputes each fogged color/alpha word from a shadow copy
// of the registers and compares every output word field by field. Covers
// reset defaults, register extremes, tiny far distances, gains above 256,
// an unused register index, random register sets and a long output hold.
// ----------------------------------------------------------------------------
module vertex_distance_fog_blend_tb;
  import fogb_pkg::*;

  localparam int         ClkPeriod  = 20;
  localparam int         CycleLimit = 200000;
  localparam int         DrainPause = 12;
  localparam int         ShowLimit  = 40;
  localparam logic [2:0] CfgUnused  = 3'd7;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               eob;
  } vertex_t;

  typedef struct packed {
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
    logic [7:0]   alpha;
    fogb_region_e region;
    logic         done;
  } fog_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [15:0] vert_x_i;
  logic signed [15:0] vert_y_i;
  logic signed [15:0] vert_z_i;
  logic [7:0] orig_red_i;
  logic [7:0] orig_green_i;
  logic [7:0] orig_blue_i;
  logic end_of_batch_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [7:0] out_red_o;
  logic [7:0] out_green_o;
  logic [7:0] out_blue_o;
  logic [7:0] out_alpha_o;
  logic [1:0] fog_region_o;
  logic batch_done_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [23:0] cfg_data_i;

  // shadow register file
  logic [23:0]        shd_fog_rgb;
  logic [15:0]        shd_near;
  logic [15:0]        shd_far;
  logic [8:0]         shd_gain;
  logic signed [15:0] shd_cam [3];

  fog_word_t fog_expect_q [$];
  fog_word_t due_word;

  int  errors = 0;
  int  mismatch_shown = 0;
  int  vertices_sent = 0;
  int  words_checked = 0;
  int  cfg_writes = 0;
  int  input_stall_cycles = 0;
  int  cycle_count = 0;
  int  region_count [3] = '{0, 0, 0};
  int  hold_req = 0;
  bit  hold_active = 1'b0;
  bit  no_idle = 1'b0;

  vertex_distance_fog_blend dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .vert_x_i       (vert_x_i),
    .vert_y_i       (vert_y_i),
    .vert_z_i       (vert_z_i),
    .orig_red_i     (orig_red_i),
    .orig_green_i   (orig_green_i),
    .orig_blue_i    (orig_blue_i),
    .end_of_batch_i (end_of_batch_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .out_alpha_o    (out_alpha_o),
    .fog_region_o   (fog_region_o),
    .batch_done_o   (batch_done_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d words still due", $time, cycle_count,
               fog_expect_q.size());
      $display("** vertex_distance_fog_blend: FAILED **");
      $finish;
    end
  end

  function automatic fog_word_t predict_fog(vertex_t v);
    int          d [3];
    logic [31:0] sum, near2, far2, divisor, f, inv, t;
    logic [7:0]  org [3];
    logic [7:0]  fogc [3];
    fog_word_t   r;
    d[0] = 16'(shd_cam[0] - v.x);
    d[1] = 16'(shd_cam[1] - v.y);
    d[2] = 16'(shd_cam[2] - v.z);
    for (int k = 0; k < 3; k++) begin
      d[k] = (d[k] >= 32768) ? d[k] - 65536 : d[k];
    end
    sum   = 32'(d[0] * d[0]) + 32'(d[1] * d[1]) + 32'(d[2] * d[2]);
    near2 = 32'(shd_near) * 32'(shd_near);
    far2  = 32'(shd_far) * 32'(shd_far);
    sum   = sum - near2;
    org[0]  = v.red & ChanKeep;
    org[1]  = v.green & ChanKeep;
    org[2]  = v.blue & ChanKeep;
    fogc[0] = shd_fog_rgb[23:16];
    fogc[1] = shd_fog_rgb[15:8];
    fogc[2] = shd_fog_rgb[7:0];
    r.done  = v.eob;
    if (sum[31]) begin
      r.region = RegionNear;
      {r.red, r.green, r.blue} = {org[0], org[1], org[2]};
      r.alpha = (shd_gain > 9'd255) ? 8'd255 : shd_gain[7:0];
    end else if (sum > far2) begin
      r.region = RegionFar;
      {r.red, r.green, r.blue} = shd_fog_rgb;
      r.alpha = 8'd0;
    end else begin
      r.region = RegionBlend;
      divisor = far2 >> FracBits;
      if (divisor == 0) divisor = 1;
      f = sum / divisor;
      if (f > FullScale) f = FullScale;
      inv = FullScale - f;
      t = 32'(org[0]) * inv + 32'(fogc[0]) * f;
      r.red = 8'(t >> FracBits);
      t = 32'(org[1]) * inv + 32'(fogc[1]) * f;
      r.green = 8'(t >> FracBits);
      t = 32'(org[2]) * inv + 32'(fogc[2]) * f;
      r.blue = 8'(t >> FracBits);
      t = (((inv * inv) >> FracBits) * 32'(shd_gain)) >> FracBits;
      r.alpha = (t > 255) ? 8'd255 : t[7:0];
    end
    return r;
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      errors++;
      if (mismatch_shown < ShowLimit) begin
        mismatch_shown++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fog_expect_q.size() == 0) begin
        errors++;
        if (mismatch_shown < ShowLimit) begin
          mismatch_shown++;
          $display("%0t: output word with nothing due, expected none actual rgb=%h", $time,
                   {out_red_o, out_green_o, out_blue_o});
        end
      end else begin
        due_word = fog_expect_q.pop_front();
        check_field("out_red", due_word.red, out_red_o);
        check_field("out_green", due_word.green, out_green_o);
        check_field("out_blue", due_word.blue, out_blue_o);
        check_field("out_alpha", due_word.alpha, out_alpha_o);
        check_field("fog_region", due_word.region, fog_region_o);
        check_field("batch_done", due_word.done, batch_done_o);
        words_checked++;
        region_count[due_word.region]++;
      end
    end
    if (rst_ni && in_valid_i && in_stall_o) input_stall_cycles++;
  end

  // output side: random stalls, quiet stretches and requested long holds
  initial begin : receiver_idle
    int len;
    int r;
    bit s;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req > 0) begin
        len = hold_req;
        hold_req = 0;
        hold_active = 1'b1;
        s = 1'b1;
      end else if (no_idle) begin
        hold_active = 1'b0;
        s = 1'b0;
        len = 1;
      end else begin
        hold_active = 1'b0;
        r = $urandom_range(0, 99);
        s = (r < 30);
        if (r < 3) len = $urandom_range(15, 50);
        else if (s) len = $urandom_range(1, 4);
        else len = $urandom_range(1, 6);
      end
      out_stall_i <= s;
      repeat (len) @(negedge clk_i);
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic vertex_t make_vertex(int x, int y, int z, logic [7:0] r, logic [7:0] g,
                                          logic [7:0] b, logic eob);
    vertex_t v;
    v.x = 16'(x);
    v.y = 16'(y);
    v.z = 16'(z);
    {v.red, v.green, v.blue, v.eob} = {r, g, b, eob};
    return v;
  endfunction

  // offsets scaled to the current near/far so every region is reached
  function automatic vertex_t random_vertex();
    int      span;
    int      sel;
    vertex_t v;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1:       span = int'(shd_near) / 2 + 1;
      2, 3, 4, 5: span = int'(shd_far) * 3 / 5 + 1;
      6, 7:       span = int'(shd_far) + 1;
      default:    span = 0;
    endcase
    if (span == 0) begin
      v.x = 16'($urandom);
      v.y = 16'($urandom);
      v.z = 16'($urandom);
    end else begin
      v.x = 16'(shd_cam[0] + int'($urandom_range(0, 2 * span)) - span);
      v.y = 16'(shd_cam[1] + int'($urandom_range(0, 2 * span)) - span);
      v.z = 16'(shd_cam[2] + int'($urandom_range(0, 2 * span)) - span);
    end
    v.red   = 8'($urandom);
    v.green = 8'($urandom);
    v.blue  = 8'($urandom);
    v.eob   = ($urandom_range(0, 5) == 0);
    return v;
  endfunction

  // called at a falling edge; leaves valid high after the word is taken
  task automatic send_vertex(vertex_t v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    vert_x_i       <= v.x;
    vert_y_i       <= v.y;
    vert_z_i       <= v.z;
    orig_red_i     <= v.red;
    orig_green_i   <= v.green;
    orig_blue_i    <= v.blue;
    end_of_batch_i <= v.eob;
    do @(posedge clk_i); while (in_stall_o);
    fog_expect_q.push_back(predict_fog(v));
    vertices_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_batch(int n);
    repeat (n) send_vertex(random_vertex());
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (fog_expect_q.size() != 0) @(negedge clk_i);
    repeat (DrainPause) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgFogColor:  shd_fog_rgb = data;
      CfgNearDist:  shd_near    = data[15:0];
      CfgFarDist:   shd_far     = data[15:0];
      CfgAlphaGain: shd_gain    = data[8:0];
      CfgCamX:      shd_cam[0]  = data[15:0];
      CfgCamY:      shd_cam[1]  = data[15:0];
      CfgCamZ:      shd_cam[2]  = data[15:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // unused upper data bits are filled at random; the block must mask them
  task automatic load_registers(logic [23:0] fog, logic [15:0] near, logic [15:0] far,
                                logic [8:0] gain, logic [15:0] cx, logic [15:0] cy,
                                logic [15:0] cz);
    drain_pipeline();
    write_reg(CfgFogColor, fog);
    write_reg(CfgNearDist, {8'($urandom), near});
    write_reg(CfgFarDist, {8'($urandom), far});
    write_reg(CfgAlphaGain, {15'($urandom), gain});
    write_reg(CfgCamX, {8'($urandom), cx});
    write_reg(CfgCamY, {8'($urandom), cy});
    write_reg(CfgCamZ, {8'($urandom), cz});
  endtask

  task automatic test_reset_defaults();
    send_vertex(make_vertex(0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_vertex(make_vertex(1000, 0, 0, 8'h07, 8'hF8, 8'h00, 1'b0));
    send_vertex(make_vertex(5000, 0, 0, 8'hA5, 8'h5A, 8'hFF, 1'b0));
    send_vertex(make_vertex(0, -9000, 4000, 8'hFF, 8'h00, 8'h80, 1'b1));
    send_vertex(make_vertex(3000, 3000, 3000, 8'h3C, 8'hC3, 8'h7F, 1'b0));
    send_vertex(make_vertex(18000, 0, 0, 8'h00, 8'hFF, 8'h00, 1'b0));
    // sum minus near squared lands exactly on far squared
    send_vertex(make_vertex(18750, 1250, 0, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_vertex(make_vertex(18750, 1251, 0, 8'h12, 8'h34, 8'h56, 1'b1));
    // sum of squares wraps past bit 31
    send_vertex(make_vertex(32767, 32767, 32767, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_vertex(make_vertex(-32768, -32768, -32768, 8'h00, 8'h00, 8'h00, 1'b1));
    send_vertex(make_vertex(-32768, 0, 0, 8'h80, 8'h40, 8'h20, 1'b0));
    send_vertex(make_vertex(20000, -20000, 0, 8'h55, 8'hAA, 8'h55, 1'b0));
    send_vertex(make_vertex(0, 0, -32768, 8'h00, 8'h00, 8'h00, 1'b0));
  endtask

  task automatic test_unused_index();
    drain_pipeline();
    write_reg(CfgUnused, 24'hFFFFFF);
    send_vertex(make_vertex(0, 0, 0, 8'hC8, 8'h19, 8'hE7, 1'b1));
    send_vertex(make_vertex(18000, 0, 0, 8'hFF, 8'h00, 8'hFF, 1'b0));
    send_batch(2);
  endtask

  task automatic test_register_extremes();
    load_registers(24'hFFFFFF, 16'd0, 16'd65535, 9'd256, 16'h7FFF, 16'h8000, 16'h0000);
    send_vertex(make_vertex(32767, -32768, 0, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_batch(10);
    load_registers(24'h000000, 16'd65535, 16'd16, 9'd0, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_vertex(make_vertex(-32768, 32767, -1, 8'hFF, 8'h00, 8'hFF, 1'b1));
    send_batch(10);
    // far distance below 16: divisor forced to one
    load_registers(24'h00FF00, 16'd0, 16'd0, 9'd511, 16'h0000, 16'h0000, 16'h0000);
    send_batch(8);
    load_registers(24'h0F0F0F, 16'd2, 16'd15, 9'd257, 16'h0040, 16'hFFC0, 16'h0001);
    send_batch(10);
    // factor above full scale gets clamped
    load_registers(24'hF0F0F0, 16'd3, 16'd17, 9'd300, 16'd100, -16'sd100, 16'd5);
    send_batch(10);
  endtask

  task automatic test_random_phases();
    logic [15:0] near;
    logic [15:0] far;
    logic [8:0]  gain;
    for (int p = 0; p < 8; p++) begin
      near = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
      if ($urandom_range(0, 9) < 8) far = 16'(near + $urandom_range(16, 30000));
      else far = 16'($urandom);
      if (far < near) far = 16'd65535;
      gain = ($urandom_range(0, 9) < 7) ? 9'($urandom_range(0, 256)) : 9'($urandom);
      load_registers(24'($urandom), near, far, gain, 16'($urandom), 16'($urandom),
                     16'($urandom));
      no_idle = (p % 3 == 0);
      send_batch(45);
      no_idle = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    load_registers(24'($urandom), 16'd500, 16'd9000, 9'd200, 16'($urandom),
                   16'($urandom), 16'($urandom));
    no_idle = 1'b1;
    hold_req = 80;
    wait (hold_active);
    send_batch(30);
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    vert_x_i       = '0;
    vert_y_i       = '0;
    vert_z_i       = '0;
    orig_red_i     = '0;
    orig_green_i   = '0;
    orig_blue_i    = '0;
    end_of_batch_i = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    shd_fog_rgb    = 24'd1054789;
    shd_near       = 16'd1250;
    shd_far        = 16'd18750;
    shd_gain       = 9'd153;
    shd_cam        = '{16'sd0, 16'sd0, 16'sd0};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_unused_index();
    test_register_extremes();
    test_random_phases();
    test_backpressure();
    drain_pipeline();

    $display("Checked %0d of %0d vertex words over %0d register writes", words_checked,
             vertices_sent, cfg_writes);
    $display("Regions near/blend/far: %0d/%0d/%0d, input held off %0d cycles",
             region_count[0], region_count[1], region_count[2], input_stall_cycles);
    if (errors == 0 && fog_expect_q.size() == 0) begin
      $display("** vertex_distance_fog_blend: PASSED **");
    end else begin
      $display("** vertex_distance_fog_blend: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
src/fogb_pkg.sv
src/fogb_dist.sv
src/fogb_div.sv
src/fogb_blend.sv
src/vertex_distance_fog_blend.sv
tb/sv/vertex_distance_fog_blend_tb.sv
